// ===== sv/assert_macros.svh =====
// Assertion macros shared by the decoder modules.
// Needs a clock named clk_i and an active-low reset named rst_ni in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, prop)
`define ASSERT_NEVER(name, cond)

`endif

`endif

// ===== sv/ctcgd_pkg.sv =====
// Shared constants and types of the CTC greedy decoder.
// No dependencies.
package ctcgd_pkg;

  localparam int unsigned ScoreW         = 16;
  localparam int unsigned LaneW          = 4;
  localparam int unsigned NumClassesDef  = 128;
  localparam int unsigned MaxFramesDef   = 4096;
  localparam int unsigned QueueDepthDef  = 2;

  // Frame-level flags carried with one request from the front to the back.
  typedef struct packed {
    logic frame_end;
    logic seq_end;
  } frame_flags_t;

endpackage

// ===== sv/ctcgd_fifo.sv =====
// Small register-based FIFO used between the decoder parts and at the result side.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ctcgd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_ptr_q];

  // Pointers wrap at the last entry, so any depth works.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

  `ASSERT_NEVER(a_count_overflow, count_q > CntFull)
  `ASSERT_PROP(a_ptrs_meet_when_empty, (count_q == '0) |-> (rd_ptr_q == wr_ptr_q))
  `ASSERT_PROP(a_push_only_grows, (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))

endmodule

// ===== sv/ctcgd_front.sv =====
// Front part: tracks the running first maximum of the current frame and
// issues one request per frame end or sequence end. Depends on ctcgd_pkg.
module ctcgd_front #(
  parameter int unsigned NUM_CLASSES = ctcgd_pkg::NumClassesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  input  logic [ctcgd_pkg::ScoreW-1:0]    score_i,
  input  logic                            frame_end_i,
  input  logic                            sequence_end_i,
  output logic                            req_valid_o,
  output logic [ctcgd_pkg::ScoreW-1:0]    req_score_o,
  output logic [$clog2(NUM_CLASSES)-1:0]  req_class_o,
  output ctcgd_pkg::frame_flags_t         req_flags_o
);

  localparam int unsigned ClassW = $clog2(NUM_CLASSES);
  localparam logic [ClassW-1:0] ClassMax = ClassW'(NUM_CLASSES - 1);

  logic [ClassW-1:0]            class_cnt_q, class_cnt_d;
  logic [ctcgd_pkg::ScoreW-1:0] best_score_q, best_score_d;
  logic [ClassW-1:0]            best_class_q, best_class_d;
  logic                         take;
  logic [ctcgd_pkg::ScoreW-1:0] cur_score;
  logic [ClassW-1:0]            cur_class;
  logic                         close;

  // The first class of a frame always wins; later ones only on a strictly higher score.
  assign take      = (class_cnt_q == '0) || (score_i > best_score_q);
  assign cur_score = take ? score_i : best_score_q;
  assign cur_class = take ? class_cnt_q : best_class_q;
  assign close     = frame_end_i || sequence_end_i;

  assign req_valid_o           = item_valid_i && close;
  assign req_score_o           = cur_score;
  assign req_class_o           = cur_class;
  assign req_flags_o.frame_end = frame_end_i;
  assign req_flags_o.seq_end   = sequence_end_i;

  always_comb begin
    class_cnt_d  = class_cnt_q;
    best_score_d = best_score_q;
    best_class_d = best_class_q;
    if (item_valid_i) begin
      if (close) begin
        class_cnt_d  = '0;
        best_score_d = '0;
        best_class_d = '0;
      end else begin
        best_score_d = cur_score;
        best_class_d = cur_class;
        if (class_cnt_q != ClassMax) begin
          class_cnt_d = class_cnt_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      class_cnt_q  <= '0;
      best_score_q <= '0;
      best_class_q <= '0;
    end else begin
      class_cnt_q  <= class_cnt_d;
      best_score_q <= best_score_d;
      best_class_q <= best_class_d;
    end
  end

endmodule

// ===== sv/ctcgd_back.sv =====
// Back part: applies frame results to the pending segment and emits closed segments.
// Depends on ctcgd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ctcgd_back #(
  parameter int unsigned NUM_CLASSES = ctcgd_pkg::NumClassesDef,
  parameter int unsigned MAX_FRAMES  = ctcgd_pkg::MaxFramesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  logic [ctcgd_pkg::ScoreW-1:0]    req_score_i,
  input  logic [$clog2(NUM_CLASSES)-1:0]  req_class_i,
  input  ctcgd_pkg::frame_flags_t         req_flags_i,
  output logic                            req_pop_o,
  input  logic                            out_full_i,
  output logic                            out_push_o,
  output logic [$clog2(NUM_CLASSES)-1:0]  out_label_o,
  output logic [$clog2(MAX_FRAMES)-1:0]   out_frame_o
);

  localparam int unsigned ClassW = $clog2(NUM_CLASSES);
  localparam int unsigned FrameW = $clog2(MAX_FRAMES);
  localparam logic [FrameW-1:0] FrameMax = FrameW'(MAX_FRAMES - 1);

  logic                         pend_valid_q, pend_valid_d;
  logic [ctcgd_pkg::ScoreW-1:0] pend_score_q, pend_score_d;
  logic [ClassW-1:0]            pend_class_q, pend_class_d;
  logic [FrameW-1:0]            pend_frame_q, pend_frame_d;
  logic [FrameW-1:0]            frame_cnt_q, frame_cnt_d;
  logic                         take_req;
  logic                         blank_win;

  // A request is only taken when the result queue has room for a possible emit.
  assign take_req    = req_valid_i && !out_full_i;
  assign req_pop_o   = take_req;
  assign blank_win   = req_flags_i.frame_end && (req_class_i == '0);
  assign out_push_o  = take_req && blank_win && pend_valid_q;
  assign out_label_o = pend_class_q;
  assign out_frame_o = pend_frame_q;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_score_d = pend_score_q;
    pend_class_d = pend_class_q;
    pend_frame_d = pend_frame_q;
    frame_cnt_d  = frame_cnt_q;
    if (take_req) begin
      if (req_flags_i.frame_end) begin
        if (blank_win) begin
          pend_valid_d = 1'b0;
          pend_score_d = '0;
          pend_class_d = '0;
          pend_frame_d = '0;
        end else if (req_score_i > pend_score_q) begin
          pend_valid_d = 1'b1;
          pend_score_d = req_score_i;
          pend_class_d = req_class_i;
          pend_frame_d = frame_cnt_q;
        end
        if (frame_cnt_q != FrameMax) begin
          frame_cnt_d = frame_cnt_q + 1'b1;
        end
      end
      if (req_flags_i.seq_end) begin
        pend_valid_d = 1'b0;
        pend_score_d = '0;
        pend_class_d = '0;
        pend_frame_d = '0;
        frame_cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_score_q <= '0;
      pend_class_q <= '0;
      pend_frame_q <= '0;
      frame_cnt_q  <= '0;
    end else begin
      pend_valid_q <= pend_valid_d;
      pend_score_q <= pend_score_d;
      pend_class_q <= pend_class_d;
      pend_frame_q <= pend_frame_d;
      frame_cnt_q  <= frame_cnt_d;
    end
  end

  `ASSERT_PROP(a_seq_end_clears, (take_req && req_flags_i.seq_end) |=> (!pend_valid_q && (frame_cnt_q == '0)))
  `ASSERT_PROP(a_emit_has_label, out_push_o |-> (pend_class_q != '0))
  `ASSERT_PROP(a_pending_score_nonzero, pend_valid_q |-> (pend_score_q != '0))
  `ASSERT_PROP(a_frame_cnt_saturates, (take_req && !req_flags_i.seq_end && (frame_cnt_q == FrameMax)) |=> (frame_cnt_q == FrameMax))

endmodule

// ===== sv/ctc_greedy_decoder.sv =====
// CTC greedy decoder for one selected lane. Accepts one score item per cycle unless full;
// frame requests pass the request queue and results the result queue. Sustained throughput
// is one item per cycle while no queue is full, set by the combinational front compare and
// the one request per cycle back update. Asynchronous active-low reset clears the frame and
// segment state, both queues and the lane select (lane 0); no clearing pass is needed.
module ctc_greedy_decoder #(
  parameter int unsigned NUM_CLASSES = ctcgd_pkg::NumClassesDef,
  parameter int unsigned MAX_FRAMES  = ctcgd_pkg::MaxFramesDef,
  parameter int unsigned QUEUE_DEPTH = ctcgd_pkg::QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ctcgd_pkg::LaneW-1:0]    cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [ctcgd_pkg::ScoreW-1:0]   score_i,
  input  logic [ctcgd_pkg::LaneW-1:0]    lane_i,
  input  logic                           frame_end_i,
  input  logic                           sequence_end_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [$clog2(NUM_CLASSES)-1:0] label_o,
  output logic [$clog2(MAX_FRAMES)-1:0]  frame_index_o
);

  localparam int unsigned ClassW = $clog2(NUM_CLASSES);
  localparam int unsigned FrameW = $clog2(MAX_FRAMES);
  localparam int unsigned ReqW   = ctcgd_pkg::ScoreW + ClassW + 2;
  localparam int unsigned OutW   = ClassW + FrameW;

  logic [ctcgd_pkg::LaneW-1:0]  lane_sel_q;
  logic                         item_valid;
  logic                         fr_req_valid;
  logic [ctcgd_pkg::ScoreW-1:0] fr_req_score;
  logic [ClassW-1:0]            fr_req_class;
  ctcgd_pkg::frame_flags_t      fr_req_flags;
  logic [ReqW-1:0]              req_wdata, req_rdata;
  logic                         req_full, req_empty, req_pop;
  logic [ctcgd_pkg::ScoreW-1:0] bk_req_score;
  logic [ClassW-1:0]            bk_req_class;
  ctcgd_pkg::frame_flags_t      bk_req_flags;
  logic                         out_full, out_push;
  logic [ClassW-1:0]            out_label;
  logic [FrameW-1:0]            out_frame;
  logic [OutW-1:0]              out_wdata, out_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_sel_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lane_sel_q <= cfg_data_i;
    end
  end

  // Items of other lanes are accepted and dropped without touching any state.
  assign full       = req_full;
  assign item_valid = push && !req_full && (lane_i == lane_sel_q);

  ctcgd_front #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .score_i        (score_i),
    .frame_end_i    (frame_end_i),
    .sequence_end_i (sequence_end_i),
    .req_valid_o    (fr_req_valid),
    .req_score_o    (fr_req_score),
    .req_class_o    (fr_req_class),
    .req_flags_o    (fr_req_flags)
  );

  assign req_wdata = {fr_req_score, fr_req_class, fr_req_flags};

  ctcgd_fifo #(
    .WIDTH (ReqW),
    .DEPTH (QUEUE_DEPTH)
  ) u_req_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_req_valid),
    .data_i  (req_wdata),
    .full_o  (req_full),
    .pop_i   (req_pop),
    .data_o  (req_rdata),
    .empty_o (req_empty)
  );

  assign bk_req_score = req_rdata[ReqW-1 -: ctcgd_pkg::ScoreW];
  assign bk_req_class = req_rdata[ClassW+1 : 2];
  assign bk_req_flags = ctcgd_pkg::frame_flags_t'(req_rdata[1:0]);

  ctcgd_back #(
    .NUM_CLASSES (NUM_CLASSES),
    .MAX_FRAMES  (MAX_FRAMES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (!req_empty),
    .req_score_i (bk_req_score),
    .req_class_i (bk_req_class),
    .req_flags_i (bk_req_flags),
    .req_pop_o   (req_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_label_o (out_label),
    .out_frame_o (out_frame)
  );

  assign out_wdata = {out_label, out_frame};

  ctcgd_fifo #(
    .WIDTH (OutW),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_rdata),
    .empty_o (empty)
  );

  assign label_o       = out_rdata[OutW-1 -: ClassW];
  assign frame_index_o = out_rdata[FrameW-1:0];

endmodule
